// ===== rtl/dnls_pkg.sv =====
// Shared codes and types for the day/night light switch.
package dnls_pkg;

   // Width of the reported average level.
   localparam int unsigned AVG_OUT_W = 16;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_DECISION_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF_LEVEL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LED_DUTY       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STABLE_TICKS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP_TICKS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_START_INVERTED = 3'd5;

   typedef enum logic [1:0] {
      MODE_SDK_FLAG      = 2'd0,
      MODE_ZERO_NIGHT    = 2'd1,
      MODE_NONZERO_NIGHT = 2'd2,
      MODE_AUTO          = 2'd3
   } mode_type;

   // Result transition codes.
   localparam logic [1:0] TRANS_NONE     = 2'd0;
   localparam logic [1:0] TRANS_TO_DAY   = 2'd1;
   localparam logic [1:0] TRANS_TO_NIGHT = 2'd2;

   // Present IR mode codes (others mean "other").
   localparam logic [1:0] IR_DAY   = 2'd0;
   localparam logic [1:0] IR_NIGHT = 2'd1;

   // Manual override codes (others mean automatic).
   localparam logic [1:0] OVR_FORCE_DAY   = 2'd1;
   localparam logic [1:0] OVR_FORCE_NIGHT = 2'd2;

   // Processor flag codes (others mean unavailable).
   localparam logic [1:0] SDK_DAY   = 2'd0;
   localparam logic [1:0] SDK_NIGHT = 2'd1;

endpackage

// ===== rtl/day_night_light_switch_core.sv =====
// Day/night light switch: input register, per-tick decision logic, result register.
//
// Usage:
//  - Request channel (req_*): one transfer per control tick, carrying the ISP
//    read status, the present IR mode, the manual override, the averaged light
//    sample and the processor day/night flag.
//  - Response channel (rsp_*): exactly one transfer per request, in order:
//    transition code, LED duty, polarity-flip flag, average level, raw wish.
//  - CSR port: plain write port (csr_wr_en, csr_index, csr_wdata). Write only
//    while no tick is in flight. Writing start_inverted also loads the learned
//    polarity.
//  - Order: a request is captured in the input register, then moves on to the
//    result register, where rsp_valid rises and the response is offered.
//    Throughput: one tick per cycle while no response is stalled; the debounce
//    and average state is a single register set updated as the tick leaves the
//    input register, so consecutive ticks see each other's updates.
//  - Stall: when rsp_stall holds a valid response, the tick in the input
//    register waits and req_stall rises only once that register is occupied;
//    a stalled response holds its payload.
//  - Reset (synchronous, active high): CSRs go to their defaults, the average
//    is marked empty, polarity, debounce and disagreement counts clear, and
//    both pipeline registers drain.
module day_night_light_switch_core #(
   parameter int LEVEL_BITS      = 16,
   parameter int FRACTION_BITS   = 8,
   parameter int HYSTERESIS_BAND = 100
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_isp_read_ok,
   input  logic [1:0]                        req_current_ir_mode,
   input  logic [1:0]                        req_manual_override,
   input  logic [LEVEL_BITS-1:0]             req_adc_mean,
   input  logic [1:0]                        req_sdk_flag,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_transition,
   output logic [7:0]                        rsp_led_drive,
   output logic                              rsp_polarity_flipped,
   output logic [dnls_pkg::AVG_OUT_W-1:0]    rsp_average_level,
   output logic                              rsp_night_wish,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [dnls_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dnls_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dnls_pkg::*;

   localparam int ACC_W   = LEVEL_BITS + FRACTION_BITS;
   localparam int CMP_W   = (LEVEL_BITS > 17) ? LEVEL_BITS : 17;
   localparam int PAD_W   = (LEVEL_BITS > AVG_OUT_W) ? LEVEL_BITS : AVG_OUT_W;
   localparam logic [CMP_W-1:0] BAND = CMP_W'(HYSTERESIS_BAND);

   // ---------------- configuration registers ----------------
   mode_type          decision_mode_ff;
   logic [15:0]       cutoff_level_ff;
   logic [7:0]        led_duty_ff;
   logic [3:0]        stable_ticks_ff;
   logic [7:0]        flip_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decision_mode_ff <= MODE_AUTO;
         cutoff_level_ff  <= 16'd500;
         led_duty_ff      <= 8'd100;
         stable_ticks_ff  <= 4'd3;
         flip_ticks_ff    <= 8'd5;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DECISION_MODE: decision_mode_ff <= mode_type'(csr_wdata[1:0]);
            CSR_CUTOFF_LEVEL:  cutoff_level_ff  <= csr_wdata;
            CSR_LED_DUTY:      led_duty_ff      <= csr_wdata[7:0];
            CSR_STABLE_TICKS:  stable_ticks_ff  <= csr_wdata[3:0];
            CSR_FLIP_TICKS:    flip_ticks_ff    <= csr_wdata[7:0];
            default: ;  // start_inverted lives in the polarity register
         endcase
      end
   end

   // ---------------- input register ----------------
   logic                  s1_valid_ff;
   logic                  s1_ok_ff;
   logic [1:0]            s1_cur_ff;
   logic [1:0]            s1_ovr_ff;
   logic [LEVEL_BITS-1:0] s1_adc_ff;
   logic [1:0]            s1_sdk_ff;

   logic out_free;   // result register can take a new tick this cycle
   logic advance;    // tick moves from input register to result register
   logic req_take;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ok_ff  <= req_isp_read_ok;
         s1_cur_ff <= req_current_ir_mode;
         s1_ovr_ff <= req_manual_override;
         s1_adc_ff <= req_adc_mean;
         s1_sdk_ff <= req_sdk_flag;
      end
   end

   // ---------------- tick state ----------------
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              acc_valid_ff, acc_valid_in;
   logic              polarity_ff, polarity_in;
   logic signed [4:0] count_ff, count_in;
   logic [7:0]        disagree_ff, disagree_in;

   // Average level, round half up, wrapped to LEVEL_BITS.
   function automatic logic [LEVEL_BITS-1:0] round_acc(input logic [ACC_W-1:0] acc);
      logic [ACC_W:0] sum;
      sum = {1'b0, acc} + ((ACC_W+1)'(1) << (FRACTION_BITS - 1));
      return sum[ACC_W-1:FRACTION_BITS];
   endfunction

   // Hysteresis band bounds.
   logic [CMP_W-1:0] cutoff_c, band_low, band_high;
   assign cutoff_c  = CMP_W'(cutoff_level_ff);
   assign band_low  = (cutoff_c > BAND) ? (cutoff_c - BAND) : '0;
   assign band_high = cutoff_c + BAND;

   function automatic logic auto_wish(input logic [LEVEL_BITS-1:0] avg,
                                      input logic [1:0] cur,
                                      input logic inv,
                                      input logic [CMP_W-1:0] lo,
                                      input logic [CMP_W-1:0] hi);
      logic [CMP_W-1:0] a;
      logic dark, light, res;
      a     = CMP_W'(avg);
      dark  = inv ? (a > hi) : (a < lo);
      light = inv ? (a < lo) : (a > hi);
      if (cur == IR_NIGHT) begin
         res = !light;
      end else if (cur == IR_DAY) begin
         res = dark;
      end else begin
         res = 1'b0;
      end
      return res;
   endfunction

   // EMA update: acc = 3 * (s << (F-2)) + ((acc + 2) >> 2); first sample seeds.
   logic [ACC_W-1:0] acc_base, sample_term;
   logic [ACC_W:0]   three_term, quarter_term, acc_sum;
   logic [ACC_W-1:0] acc_upd;
   logic [LEVEL_BITS-1:0] avg_upd;

   assign acc_base     = acc_valid_ff ? acc_ff : (ACC_W'(s1_adc_ff) << FRACTION_BITS);
   assign sample_term  = ACC_W'(s1_adc_ff) << (FRACTION_BITS - 2);
   assign three_term   = ({1'b0, sample_term} << 1) + {1'b0, sample_term};
   assign quarter_term = ({1'b0, acc_base} + (ACC_W+1)'(2)) >> 2;
   assign acc_sum      = three_term + quarter_term;
   assign acc_upd      = acc_sum[ACC_W-1:0];  // bounded by max sample << F
   assign avg_upd      = round_acc(acc_upd);

   // Debounce threshold, zero treated as one.
   logic signed [4:0] need;
   assign need = (stable_ticks_ff == 4'd0) ? 5'sd1 : $signed({1'b0, stable_ticks_ff});

   logic [1:0]            trans;
   logic                  flipped;
   logic                  wish;
   logic [LEVEL_BITS-1:0] avg_lvl;
   logic                  force_night;
   logic [8:0]            disagree_inc;
   logic signed [4:0]     count_step;

   assign disagree_inc = {1'b0, disagree_ff} + 9'd1;
   assign force_night  = (s1_ovr_ff == OVR_FORCE_NIGHT);

   always_comb begin
      acc_in       = acc_ff;
      acc_valid_in = acc_valid_ff;
      polarity_in  = polarity_ff;
      count_in     = count_ff;
      disagree_in  = disagree_ff;
      trans        = TRANS_NONE;
      flipped      = 1'b0;
      wish         = 1'b0;
      avg_lvl      = '0;
      count_step   = count_ff;

      if (!s1_ok_ff) begin
         // skipped tick: all-zero result, state untouched
      end else if (s1_ovr_ff == OVR_FORCE_DAY || s1_ovr_ff == OVR_FORCE_NIGHT) begin
         wish = force_night;
         if (s1_cur_ff != (force_night ? IR_NIGHT : IR_DAY)) begin
            trans = force_night ? TRANS_TO_NIGHT : TRANS_TO_DAY;
         end
         count_in = '0;
         if (decision_mode_ff == MODE_AUTO) begin
            avg_lvl = round_acc(acc_ff);
         end
      end else begin
         unique case (decision_mode_ff)
            MODE_SDK_FLAG:      wish = (s1_sdk_ff == SDK_NIGHT);
            MODE_ZERO_NIGHT:    wish = (s1_adc_ff == '0);
            MODE_NONZERO_NIGHT: wish = (s1_adc_ff != '0);
            MODE_AUTO: begin
               acc_in       = acc_upd;
               acc_valid_in = 1'b1;
               avg_lvl      = avg_upd;
               wish = auto_wish(avg_upd, s1_cur_ff, polarity_ff, band_low, band_high);
               if (s1_sdk_ff == SDK_DAY || s1_sdk_ff == SDK_NIGHT) begin
                  if (wish == (s1_sdk_ff == SDK_NIGHT)) begin
                     disagree_in = '0;
                  end else if (disagree_inc >= {1'b0, flip_ticks_ff}) begin
                     // polarity learned wrong: flip and decide again on same average
                     polarity_in = !polarity_ff;
                     disagree_in = '0;
                     flipped     = 1'b1;
                     wish = auto_wish(avg_upd, s1_cur_ff, !polarity_ff,
                                      band_low, band_high);
                  end else begin
                     disagree_in = disagree_inc[7:0];
                  end
               end
            end
            default: ;
         endcase

         // saturating up/down debounce
         if (wish) begin
            if (count_ff < need) count_step = count_ff + 5'sd1;
         end else begin
            if (count_ff > -need) count_step = count_ff - 5'sd1;
         end
         count_in = count_step;
         if (count_step == need && s1_cur_ff != IR_NIGHT) begin
            trans    = TRANS_TO_NIGHT;
            count_in = '0;
         end else if (count_step == -need && s1_cur_ff != IR_DAY) begin
            trans    = TRANS_TO_DAY;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         acc_valid_ff <= 1'b0;
         polarity_ff  <= 1'b0;
         count_ff     <= '0;
         disagree_ff  <= '0;
      end else if (advance) begin
         acc_ff       <= acc_in;
         acc_valid_ff <= acc_valid_in;
         polarity_ff  <= polarity_in;
         count_ff     <= count_in;
         disagree_ff  <= disagree_in;
      end else if (csr_wr_en && csr_index == CSR_START_INVERTED) begin
         polarity_ff <= csr_wdata[0];
      end
   end

   // ---------------- result register ----------------
   logic [PAD_W-1:0] avg_pad;
   assign avg_pad = PAD_W'(avg_lvl);

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_trans_ff;
   logic [7:0]           rsp_led_ff;
   logic                 rsp_flip_ff;
   logic [AVG_OUT_W-1:0] rsp_avg_ff;
   logic                 rsp_wish_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_trans_ff <= trans;
         rsp_led_ff   <= (trans == TRANS_TO_NIGHT) ? led_duty_ff : 8'd0;
         rsp_flip_ff  <= flipped;
         rsp_avg_ff   <= avg_pad[AVG_OUT_W-1:0];
         rsp_wish_ff  <= wish;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_transition       = rsp_trans_ff;
   assign rsp_led_drive        = rsp_led_ff;
   assign rsp_polarity_flipped = rsp_flip_ff;
   assign rsp_average_level    = rsp_avg_ff;
   assign rsp_night_wish       = rsp_wish_ff;

endmodule

// ===== rtl/dnls_checker.sv =====
// Port-level checks for the day/night light switch, bound to the top level.
module dnls_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [1:0]                     rsp_transition,
   input logic [7:0]                     rsp_led_drive,
   input logic                           rsp_polarity_flipped,
   input logic [dnls_pkg::AVG_OUT_W-1:0] rsp_average_level,
   input logic                           rsp_night_wish
);
   import dnls_pkg::*;

   // no response shows up in the cycle after reset
   a_reset_drains: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // only the three defined transition codes appear
   a_trans_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_transition == TRANS_NONE || rsp_transition == TRANS_TO_DAY ||
                     rsp_transition == TRANS_TO_NIGHT))
      else $error("undefined transition code");

   // LED is driven only on a switch to night
   a_led_night_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_transition != TRANS_TO_NIGHT) |-> rsp_led_drive == 8'd0)
      else $error("LED duty without night transition");

   // a stalled response holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_transition) &&
         $stable(rsp_led_drive) && $stable(rsp_polarity_flipped) &&
         $stable(rsp_average_level) && $stable(rsp_night_wish)))
      else $error("stalled response changed");

endmodule

bind day_night_light_switch_core dnls_checker u_dnls_checker (.*);

// ===== tb/sv/day_night_light_switch_core_checker.sv =====
// Checker for the day/night light switch: tick predictor and response scoreboard.
`timescale 1ns / 100ps
module day_night_light_switch_core_checker #(
   parameter int LEVEL_BITS      = 16,
   parameter int FRACTION_BITS   = 8,
   parameter int HYSTERESIS_BAND = 100
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_isp_read_ok,
   input  logic [1:0]                      req_current_ir_mode,
   input  logic [1:0]                      req_manual_override,
   input  logic [LEVEL_BITS-1:0]           req_adc_mean,
   input  logic [1:0]                      req_sdk_flag,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [1:0]                      rsp_transition,
   input  logic [7:0]                      rsp_led_drive,
   input  logic                            rsp_polarity_flipped,
   input  logic [dnls_pkg::AVG_OUT_W-1:0]  rsp_average_level,
   input  logic                            rsp_night_wish,
   input  logic                            csr_wr_en,
   input  logic [dnls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dnls_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                     fail_count,
   output int unsigned                     pending
);
   import dnls_pkg::*;

   typedef struct packed {
      logic [1:0]           transition;
      logic [7:0]           led_drive;
      logic                 polarity_flipped;
      logic [AVG_OUT_W-1:0] average_level;
      logic                 night_wish;
   } tick_result_type;

   // shadow CSRs
   mode_type    decision_mode;
   logic [15:0] cutoff_level;
   logic [7:0]  led_duty;
   logic [3:0]  stable_ticks;
   logic [7:0]  flip_ticks;
   logic        start_inverted;

   // shadow tick state
   longint unsigned avg_acc;
   bit              avg_seeded;
   bit              pol_inverted;
   int              stable_count;
   int unsigned     disagree_count;

   tick_result_type expected_q[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic logic [AVG_OUT_W-1:0] rounded_level();
      logic [63:0] r;
      r = (avg_acc + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
      r = r & ((64'd1 << LEVEL_BITS) - 1);
      return r[AVG_OUT_W-1:0];
   endfunction

   // Band compare; polarity decides which side is dark.
   function automatic bit night_from_level(logic [AVG_OUT_W-1:0] avg, logic [1:0] cur);
      int lo;
      int hi;
      bit dark;
      bit light;
      lo    = (int'(cutoff_level) > HYSTERESIS_BAND) ? int'(cutoff_level) - HYSTERESIS_BAND : 0;
      hi    = int'(cutoff_level) + HYSTERESIS_BAND;
      dark  = pol_inverted ? (int'(avg) > hi) : (int'(avg) < lo);
      light = pol_inverted ? (int'(avg) < lo) : (int'(avg) > hi);
      if (cur == IR_NIGHT) return !light;
      if (cur == IR_DAY) return dark;
      return 1'b0;
   endfunction

   function automatic tick_result_type predict_tick(logic ok, logic [1:0] cur,
                                                    logic [1:0] ovr,
                                                    logic [LEVEL_BITS-1:0] sample,
                                                    logic [1:0] sdk);
      tick_result_type      res;
      int                   need;
      bit                   wish;
      bit                   sdk_night;
      logic [AVG_OUT_W-1:0] avg;
      res  = '0;
      wish = 1'b0;
      need = (stable_ticks == 4'd0) ? 1 : int'(stable_ticks);
      if (!ok) return res;
      if (ovr == OVR_FORCE_DAY || ovr == OVR_FORCE_NIGHT) begin
         wish = (ovr == OVR_FORCE_NIGHT);
         if (cur != (wish ? IR_NIGHT : IR_DAY))
            res.transition = wish ? TRANS_TO_NIGHT : TRANS_TO_DAY;
         stable_count = 0;
         if (decision_mode == MODE_AUTO) res.average_level = rounded_level();
      end else begin
         case (decision_mode)
            MODE_SDK_FLAG:      wish = (sdk == SDK_NIGHT);
            MODE_ZERO_NIGHT:    wish = (sample == '0);
            MODE_NONZERO_NIGHT: wish = (sample != '0);
            default: begin
               if (!avg_seeded) begin
                  avg_acc    = 64'(sample) << FRACTION_BITS;
                  avg_seeded = 1'b1;
               end
               avg_acc = 3 * (64'(sample) << (FRACTION_BITS - 2)) + ((avg_acc + 2) >> 2);
               avg = rounded_level();
               res.average_level = avg;
               wish = night_from_level(avg, cur);
               if (sdk == SDK_DAY || sdk == SDK_NIGHT) begin
                  sdk_night = (sdk == SDK_NIGHT);
                  if (wish == sdk_night) begin
                     disagree_count = 0;
                  end else if (disagree_count + 1 >= int'(flip_ticks)) begin
                     // flip, then decide again on the same average
                     pol_inverted         = !pol_inverted;
                     disagree_count       = 0;
                     res.polarity_flipped = 1'b1;
                     wish = night_from_level(avg, cur);
                  end else begin
                     disagree_count = (disagree_count + 1) & 8'hFF;
                  end
               end
            end
         endcase
         if (wish) begin
            if (stable_count < need) stable_count++;
         end else if (stable_count > -need) begin
            stable_count--;
         end
         if (stable_count == need && cur != IR_NIGHT) begin
            res.transition = TRANS_TO_NIGHT;
            stable_count   = 0;
         end else if (stable_count == -need && cur != IR_DAY) begin
            res.transition = TRANS_TO_DAY;
            stable_count   = 0;
         end
      end
      if (res.transition == TRANS_TO_NIGHT) res.led_drive = led_duty;
      res.night_wish = wish;
      return res;
   endfunction

   task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      tick_result_type want;
      if (reset) begin
         decision_mode  = MODE_AUTO;
         cutoff_level   = 16'd500;
         led_duty       = 8'd100;
         stable_ticks   = 4'd3;
         flip_ticks     = 8'd5;
         start_inverted = 1'b0;
         avg_acc        = 0;
         avg_seeded     = 1'b0;
         pol_inverted   = 1'b0;
         stable_count   = 0;
         disagree_count = 0;
         expected_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DECISION_MODE:  decision_mode = mode_type'(csr_wdata[1:0]);
               CSR_CUTOFF_LEVEL:   cutoff_level  = csr_wdata[15:0];
               CSR_LED_DUTY:       led_duty      = csr_wdata[7:0];
               CSR_STABLE_TICKS:   stable_ticks  = csr_wdata[3:0];
               CSR_FLIP_TICKS:     flip_ticks    = csr_wdata[7:0];
               CSR_START_INVERTED: begin
                  start_inverted = csr_wdata[0];
                  pol_inverted   = csr_wdata[0];
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_q.push_back(predict_tick(req_isp_read_ok, req_current_ir_mode,
                                              req_manual_override, req_adc_mean, req_sdk_flag));
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("response transfer with no tick outstanding");
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("transition", 16'(want.transition), 16'(rsp_transition));
               check_field("led_drive", 16'(want.led_drive), 16'(rsp_led_drive));
               check_field("polarity_flipped", 16'(want.polarity_flipped),
                           16'(rsp_polarity_flipped));
               check_field("average_level", 16'(want.average_level), 16'(rsp_average_level));
               check_field("night_wish", 16'(want.night_wish), 16'(rsp_night_wish));
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

// ===== tb/sv/day_night_light_switch_core_tb.sv =====
// Top of the day/night light switch testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module day_night_light_switch_core_tb;
   import dnls_pkg::*;

   localparam int LEVEL_BITS      = 16;
   localparam int FRACTION_BITS   = 8;
   localparam int HYSTERESIS_BAND = 100;

   // Watchdog: worst case is roughly 2000 ticks, each with a long send gap and a long
   // receive stall, plus the CSR phases; this is several times that.
   localparam int unsigned CYCLE_LIMIT = 800_000;
   localparam int PHASE_COUNT      = 10;
   localparam int TICKS_PER_PHASE  = 195;
   localparam int HOLD_OFF_CYCLES  = 80;
   localparam int SETTLE_CYCLES    = 4;   // pipeline is 2 deep, a little margin

   // Codes the package leaves unnamed.
   localparam logic [1:0] IR_OTHER    = 2'd2;
   localparam logic [1:0] IR_UNKNOWN  = 2'd3;
   localparam logic [1:0] OVR_NONE    = 2'd0;
   localparam logic [1:0] OVR_UNKNOWN = 2'd3;
   localparam logic [1:0] SDK_NONE    = 2'd2;
   localparam logic [1:0] SDK_UNKNOWN = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_isp_read_ok = 1'b0;
   logic [1:0]             req_current_ir_mode = '0;
   logic [1:0]             req_manual_override = '0;
   logic [LEVEL_BITS-1:0]  req_adc_mean = '0;
   logic [1:0]             req_sdk_flag = '0;

   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_transition;
   logic [7:0]             rsp_led_drive;
   logic                   rsp_polarity_flipped;
   logic [AVG_OUT_W-1:0]   rsp_average_level;
   logic                   rsp_night_wish;

   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int unsigned fail_count;
   int unsigned pending;

   // Stimulus state
   logic [1:0]  camera_ir = IR_DAY;  // IR mode the camera would be in after applied switches
   logic [15:0] cfg_cutoff = 16'd500;
   int          light_level = 500;
   int          light_target = 500;
   bit          sdk_inverted = 1'b0;
   bit          hold_off_req = 1'b0;
   int          steady_left = 0;
   int unsigned cycle_count = 0;

   day_night_light_switch_core #(
      .LEVEL_BITS      (LEVEL_BITS),
      .FRACTION_BITS   (FRACTION_BITS),
      .HYSTERESIS_BAND (HYSTERESIS_BAND)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_isp_read_ok      (req_isp_read_ok),
      .req_current_ir_mode  (req_current_ir_mode),
      .req_manual_override  (req_manual_override),
      .req_adc_mean         (req_adc_mean),
      .req_sdk_flag         (req_sdk_flag),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_transition       (rsp_transition),
      .rsp_led_drive        (rsp_led_drive),
      .rsp_polarity_flipped (rsp_polarity_flipped),
      .rsp_average_level    (rsp_average_level),
      .rsp_night_wish       (rsp_night_wish),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   day_night_light_switch_core_checker #(
      .LEVEL_BITS      (LEVEL_BITS),
      .FRACTION_BITS   (FRACTION_BITS),
      .HYSTERESIS_BAND (HYSTERESIS_BAND)
   ) u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_isp_read_ok      (req_isp_read_ok),
      .req_current_ir_mode  (req_current_ir_mode),
      .req_manual_override  (req_manual_override),
      .req_adc_mean         (req_adc_mean),
      .req_sdk_flag         (req_sdk_flag),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_transition       (rsp_transition),
      .rsp_led_drive        (rsp_led_drive),
      .rsp_polarity_flipped (rsp_polarity_flipped),
      .rsp_average_level    (rsp_average_level),
      .rsp_night_wish       (rsp_night_wish),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .fail_count           (fail_count),
      .pending              (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog. Fires only if the run hangs or crawls.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Follow the camera: every switch the block requests is taken as applied, so the
   // next ticks report the new IR mode like the real control loop would.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if (rsp_transition == TRANS_TO_NIGHT) camera_ir <= IR_NIGHT;
         else if (rsp_transition == TRANS_TO_DAY) camera_ir <= IR_DAY;
      end
   end

   // Response side back-pressure. One assignment per chosen run; mostly short
   // stalls, some long ones, some stretches with no stall at all. A pressure
   // request from the sender gets a long, counted hold-off.
   initial begin
      int   len;
      int   r;
      logic hold;
      @(negedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (hold_off_req) begin
            hold         = 1'b1;
            len          = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
         end else if (r < 10) begin
            hold = 1'b0;
            len  = $urandom_range(30, 80);
         end else if (r < 65) begin
            hold = 1'b0;
            len  = $urandom_range(1, 6);
         end else if (r < 92) begin
            hold = 1'b1;
            len  = $urandom_range(1, 3);
         end else if (r < 98) begin
            hold = 1'b1;
            len  = $urandom_range(4, 12);
         end else begin
            hold = 1'b1;
            len  = $urandom_range(20, 40);
         end
         rsp_stall <= hold;
         repeat (len) @(negedge clock);
      end
   end

   // One request transfer: optional idle gap, then present the tick at the falling
   // edge and hold it until the block takes it. Valid stays up across back-to-back
   // transfers.
   task automatic send_tick(logic ok, logic [1:0] cur, logic [1:0] ovr,
                            logic [LEVEL_BITS-1:0] adc, logic [1:0] sdk);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      if (steady_left > 0) begin
         steady_left--;
         gap = 0;
      end else if (r < 3) begin
         steady_left = $urandom_range(20, 60);
         gap = 0;
      end else if (r < 55) begin
         gap = 0;
      end else if (r < 90) begin
         gap = $urandom_range(1, 3);
      end else if (r < 97) begin
         gap = $urandom_range(4, 10);
      end else begin
         gap = $urandom_range(20, 50);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_isp_read_ok     <= ok;
      req_current_ir_mode <= cur;
      req_manual_override <= ovr;
      req_adc_mean        <= adc;
      req_sdk_flag        <= sdk;
      req_valid           <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering and let every outstanding tick come back, plus pipeline margin.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // New CSR setting, only with the block idle. start_inverted is optional since
   // writing it throws away the learned polarity. Spare indexes get junk writes.
   task automatic configure(mode_type mode, logic [15:0] cutoff, logic [7:0] duty,
                            logic [3:0] stable, logic [7:0] flip, logic inv,
                            bit load_polarity);
      drain();
      write_csr(CSR_DECISION_MODE, 16'(mode));
      write_csr(CSR_CUTOFF_LEVEL, cutoff);
      write_csr(CSR_LED_DUTY, 16'(duty));
      write_csr(CSR_STABLE_TICKS, 16'(stable));
      write_csr(CSR_FLIP_TICKS, 16'(flip));
      if (load_polarity) write_csr(CSR_START_INVERTED, 16'(inv));
      write_csr(CSR_SPARE_6, 16'($urandom));
      write_csr(CSR_SPARE_7, 16'($urandom));
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cfg_cutoff   = cutoff;
      light_level  = int'(cutoff);
      light_target = int'(cutoff);
   endtask

   // Random ticks. Most of them follow a plausible scene: a light level that
   // drifts toward a target around the cutoff, a processor flag that tracks it
   // (with a polarity that occasionally inverts to force learning), and the
   // camera's real IR mode. The rest are skipped reads and raw noise.
   task automatic run_phase(int count, int hold_at);
      int         r;
      logic [1:0] cur;
      logic [1:0] ovr;
      logic [1:0] sdk;
      logic [15:0] adc;
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) begin
            // long receive hold-off while sending flat out: fills the pipe
            hold_off_req = 1'b1;
            steady_left  = HOLD_OFF_CYCLES + 20;
         end
         if ($urandom_range(0, 29) == 0) begin
            case ($urandom_range(0, 5))
               0:       light_target = 0;
               1:       light_target = 65535;
               default: light_target = int'(cfg_cutoff) + int'($urandom_range(0, 3000)) - 1500;
            endcase
            if (light_target < 0) light_target = 0;
            if (light_target > 65535) light_target = 65535;
         end
         light_level += (light_target - light_level) / 8 + int'($urandom_range(0, 40)) - 20;
         if (light_level < 0) light_level = 0;
         if (light_level > 65535) light_level = 65535;
         if ($urandom_range(0, 299) == 0) sdk_inverted = !sdk_inverted;

         r = $urandom_range(0, 99);
         if (r < 4) begin
            send_tick(1'b0, 2'($urandom), 2'($urandom), 16'($urandom), 2'($urandom));
         end else if (r < 9) begin
            send_tick(1'b1, 2'($urandom), 2'($urandom), 16'($urandom), 2'($urandom));
         end else begin
            cur = ($urandom_range(0, 9) == 0) ? 2'($urandom) : camera_ir;
            r   = $urandom_range(0, 99);
            if (r < 3) ovr = OVR_FORCE_DAY;
            else if (r < 6) ovr = OVR_FORCE_NIGHT;
            else if (r < 8) ovr = OVR_UNKNOWN;
            else ovr = OVR_NONE;
            adc = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'(light_level);
            if ($urandom_range(0, 9) == 0)
               sdk = $urandom_range(0, 1) ? SDK_NONE : SDK_UNKNOWN;
            else
               sdk = ((light_level < int'(cfg_cutoff)) ^ sdk_inverted) ? SDK_NIGHT : SDK_DAY;
            send_tick(1'b1, cur, ovr, adc, sdk);
         end
      end
   endtask

   initial begin
      // Synchronous reset at start, once.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed ticks at reset settings (auto, cutoff 500, stable 3, flip 5).
      // Skipped read with every other field at its all-ones value.
      send_tick(1'b0, IR_UNKNOWN, OVR_UNKNOWN, 16'hFFFF, SDK_UNKNOWN);
      // First sample seeds the average at zero: dark, three in a row switch to night.
      repeat (3) send_tick(1'b1, IR_DAY, OVR_NONE, 16'h0000, SDK_NIGHT);
      // Full-scale light while at night: average climbs, debounce back to day.
      repeat (4) send_tick(1'b1, IR_NIGHT, OVR_NONE, 16'hFFFF, SDK_DAY);
      // Manual override, both directions, with and without a mode change.
      send_tick(1'b1, IR_DAY, OVR_FORCE_DAY, 16'hAAAA, SDK_DAY);
      send_tick(1'b1, IR_NIGHT, OVR_FORCE_DAY, 16'h5555, SDK_NIGHT);
      send_tick(1'b1, IR_NIGHT, OVR_FORCE_NIGHT, 16'hAAAA, SDK_NONE);
      send_tick(1'b1, IR_OTHER, OVR_FORCE_NIGHT, 16'h5555, SDK_UNKNOWN);
      // Unknown override counts as automatic; unknown IR mode and flag codes.
      send_tick(1'b1, IR_UNKNOWN, OVR_UNKNOWN, 16'hFFFF, SDK_UNKNOWN);
      send_tick(1'b1, IR_OTHER, OVR_NONE, 16'hFFFF, SDK_NONE);
      // Bright scene while the processor insists on night: five disagreements
      // flip the polarity and the wish is re-evaluated on the same average.
      repeat (6) send_tick(1'b1, IR_DAY, OVR_NONE, 16'hFFFF, SDK_NIGHT);
      // And back again.
      repeat (3) send_tick(1'b1, IR_NIGHT, OVR_NONE, 16'h0000, SDK_DAY);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: ;  // reset settings
            1: configure(MODE_AUTO, 16'd500, 8'd255, 4'd1, 8'd1, 1'b1, 1'b1);
            2: configure(MODE_SDK_FLAG, 16'd0, 8'd0, 4'd15, 8'd255, 1'b0, 1'b1);
            3: configure(MODE_ZERO_NIGHT, 16'd2000, 8'h5A, 4'd4, 8'd3, 1'b0, 1'b0);
            4: configure(MODE_NONZERO_NIGHT, 16'd2000, 8'hA5, 4'd2, 8'd3, 1'b0, 1'b0);
            // zero debounce and zero flip thresholds, cutoff at the top
            5: configure(MODE_AUTO, 16'hFFFF, 8'd1, 4'd0, 8'd0, 1'b0, 1'b1);
            // band clipped at zero, slowest debounce and learning
            6: configure(MODE_AUTO, 16'd50, 8'd128, 4'd15, 8'd255, 1'b1, 1'b1);
            // lowered debounce threshold: saturated counts above it are kept
            7: configure(MODE_AUTO, 16'd30000, 8'd77, 4'd2, 8'd8, 1'b0, 1'b0);
            default: configure(mode_type'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                               4'($urandom), 8'($urandom), 1'($urandom),
                               1'($urandom_range(0, 1)));
         endcase
         run_phase(TICKS_PER_PHASE, (p == 2 || p == 7) ? 60 : -1);
      end

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
